>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the band kernel blur block.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hw/rtl/bkb_pkg.sv
// Package of the band kernel blur block: widths, register map, payload types
// and sequencer states. It depends on nothing else.
`default_nettype none

package bkb_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 16;
	localparam int NUM_COEFS      = 7;
	localparam int RADIUS_BITS    = 3;
	localparam int RADIUS_CAP     = 6;
	localparam int DEF_MAX_RADIUS = 6;
	localparam int COUNT_BITS     = 4;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS + 1;
	localparam int ACC_BITS       = PROD_BITS + 4;

	localparam int ADDR_BITS    = 5;
	localparam int DATA_BITS    = 32;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_RADIUS = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_COEF0  = REG_IDX_BITS'(1);

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);
	localparam logic [COEF_BITS-1:0]   COEF0_RESET  = COEF_BITS'(32768);
	localparam logic [COEF_BITS-1:0]   COEF1_RESET  = COEF_BITS'(16384);
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] band_value;
		logic                          frame_end;
	} bkb_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] blurred_value;
		logic                          last_of_frame;
	} bkb_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} bkb_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/band_kernel_blur_core.sv
// Top level of the band kernel blur block: window, shared multiply-accumulate,
// sequencer and register port. Depends on bkb_pkg and assert_macros.svh.
//
// Bands arrive on the sample channel (valid/ready), one transfer per band, with
// frame_end set on the last band of a frame. Blurred bands leave on the result
// channel (valid/ready) in band order, with last_of_frame on the final one.
// The user must write radius and coefficients through the APB port only while
// idle; the block itself does not enforce it. A band is taken only in the idle
// state. One blurred output is computed in the single multiply-accumulate unit:
// one tap per cycle over 2r+1 taps, then a drain step for the product register,
// then an emit step that applies the rounding shift, saturates and loads the
// output register. A band that releases an output thus occupies the block through
// these steps, and a band that releases none and ends no frame returns straight to
// idle. The last band of a frame adds the zero padding steps plus one pass for each
// pending output. When the receiver stalls, the finished sum waits in the accumulator
// and the sequencer holds in its emit step until the output register is free. Reset
// clears the window and band count and restores radius 1 and the default weights.
`default_nettype none
`include "assert_macros.svh"

module band_kernel_blur_core
	import bkb_pkg::*;
#(
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire bkb_in_t              sample_data,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output bkb_out_t                  result_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [DATA_BITS-1:0] pwdata,
	output logic      [DATA_BITS-1:0] prdata,
	output logic                      pready
);

	localparam int LIM = (MAX_RADIUS < RADIUS_CAP) ? MAX_RADIUS : RADIUS_CAP;
	localparam int WIN = 2 * LIM + 1;
	localparam int JW  = $clog2(WIN);
	localparam int CW  = (JW > RADIUS_BITS) ? JW : RADIUS_BITS;

	localparam logic [RADIUS_BITS-1:0]   LIM_R      = RADIUS_BITS'(LIM);
	localparam logic signed [ACC_BITS-1:0] ROUND_BIAS = ACC_BITS'(64'd1 << (COEF_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] SAT_MAX    =
		ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [ACC_BITS-1:0] SAT_MIN    = ~SAT_MAX;

	logic [RADIUS_BITS-1:0]        radius_q;
	logic [COEF_BITS-1:0]          coef_q [NUM_COEFS];
	logic signed [SAMPLE_BITS-1:0] window_q [WIN];
	logic [COUNT_BITS-1:0]         count_q;
	bkb_state_t                    state_q;
	bkb_state_t                    state_nxt;
	logic [JW-1:0]                 j_q;
	logic [RADIUS_BITS-1:0]        pad_q;
	logic [RADIUS_BITS-1:0]        left_q;
	logic                          flushing_q;
	logic                          last_q;
	logic signed [PROD_BITS-1:0]   prod_s1;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          result_valid_q;
	bkb_out_t                      result_data_q;

	logic [REG_IDX_BITS-1:0]       reg_idx;
	logic                          cfg_we;
	logic [RADIUS_BITS-1:0]        r_eff;
	logic [JW-1:0]                 two_r;
	logic [COUNT_BITS-1:0]         new_count;
	logic [RADIUS_BITS-1:0]        pend_new;
	logic [RADIUS_BITS-1:0]        pad_new;
	logic [CW-1:0]                 j_ext;
	logic [CW-1:0]                 r_ext;
	logic [CW-1:0]                 tap_dist;
	logic [COEF_BITS-1:0]          coef_sel;
	logic signed [COEF_BITS:0]     coef_ext;
	logic signed [SAMPLE_BITS-1:0] win_sel;
	logic signed [ACC_BITS-1:0]    shifted;
	logic signed [ACC_BITS-1:0]    sat_val;
	logic                          slot_free;
	logic                          accept;
	logic                          shift_zero;
	logic                          load_out;
	logic                          clear_frame;

	// Register port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign cfg_we  = psel & penable & pwrite;

	always_comb begin
		case (reg_idx)
			REG_RADIUS: prdata = DATA_BITS'(radius_q);
			default:    prdata = DATA_BITS'(coef_q[reg_idx - REG_COEF0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			coef_q[0] <= COEF0_RESET;
			coef_q[1] <= COEF1_RESET;
			for (int i = 2; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (reg_idx == REG_RADIUS) begin
				radius_q <= pwdata[RADIUS_BITS-1:0];
			end else begin
				coef_q[reg_idx - REG_COEF0] <= pwdata[COEF_BITS-1:0];
			end
		end
	end

	// Effective radius, band count and flush bookkeeping.
	always_comb begin
		if (radius_q == '0) begin
			r_eff = RADIUS_BITS'(1);
		end else if (radius_q > LIM_R) begin
			r_eff = LIM_R;
		end else begin
			r_eff = radius_q;
		end
	end

	assign two_r     = JW'({2'b00, r_eff, 1'b0});
	assign new_count = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_BITS'(1);
	assign pend_new  = (new_count < COUNT_BITS'(r_eff)) ? new_count[RADIUS_BITS-1:0] : r_eff;
	assign pad_new   = r_eff - pend_new;

	// Tap selection for the shared multiplier.
	assign j_ext    = CW'(j_q);
	assign r_ext    = CW'(r_eff);
	assign tap_dist = (j_ext >= r_ext) ? j_ext - r_ext : r_ext - j_ext;
	assign coef_sel = coef_q[tap_dist[RADIUS_BITS-1:0]];
	assign coef_ext = $signed({1'b0, coef_sel});
	assign win_sel  = window_q[j_q];

	// Rounding shift and saturation of the finished sum.
	assign shifted = acc_q >>> COEF_BITS;
	always_comb begin
		if (shifted > SAT_MAX) begin
			sat_val = SAT_MAX;
		end else if (shifted < SAT_MIN) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = shifted;
		end
	end

	assign slot_free = !result_valid_q || result_ready;

	// Sequencer: next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					if (new_count > COUNT_BITS'(r_eff)) begin
						state_nxt = ST_MAC;
					end else if (sample_data.frame_end) begin
						state_nxt = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (pad_q == '0) begin
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: begin
				if (j_q == two_r) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (flushing_q && left_q != '0) begin
						state_nxt = ST_FLUSH;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		sample_ready = (state_q == ST_IDLE);
		accept       = sample_valid && (state_q == ST_IDLE);
		shift_zero   = (state_q == ST_FLUSH);
		load_out     = (state_q == ST_EMIT) && slot_free;
		clear_frame  = load_out && flushing_q && (left_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			j_q            <= '0;
			pad_q          <= '0;
			left_q         <= '0;
			flushing_q     <= 1'b0;
			last_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q    <= new_count;
						flushing_q <= sample_data.frame_end;
						pad_q      <= pad_new;
						left_q     <= pend_new;
						last_q     <= 1'b0;
						j_q        <= '0;
					end
				end
				ST_FLUSH: begin
					if (pad_q != '0) begin
						pad_q <= pad_q - RADIUS_BITS'(1);
					end else begin
						left_q <= left_q - RADIUS_BITS'(1);
						last_q <= (left_q == RADIUS_BITS'(1));
						j_q    <= '0;
					end
				end
				ST_MAC: begin
					if (j_q != two_r) begin
						j_q <= j_q + JW'(1);
					end
				end
				default: begin
				end
			endcase
			if (clear_frame) begin
				count_q    <= '0;
				flushing_q <= 1'b0;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Sample window, newest band at entry 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				window_q[i] <= '0;
			end
		end else if (clear_frame) begin
			for (int i = 0; i < WIN; i++) begin
				window_q[i] <= '0;
			end
		end else if (accept || shift_zero) begin
			for (int i = 1; i < WIN; i++) begin
				window_q[i] <= window_q[i-1];
			end
			window_q[0] <= accept ? sample_data.band_value : '0;
		end
	end

	// Shared multiply-accumulate and output register.
	always_ff @(posedge clk) begin
		if (state_q == ST_MAC) begin
			prod_s1 <= PROD_BITS'(win_sel) * PROD_BITS'(coef_ext);
			if (j_q == '0) begin
				acc_q <= ROUND_BIAS;
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s1);
			end
		end else if (state_q == ST_DRAIN) begin
			acc_q <= acc_q + ACC_BITS'(prod_s1);
		end
		if (load_out) begin
			result_data_q.blurred_value <= sat_val[SAMPLE_BITS-1:0];
			result_data_q.last_of_frame <= last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	`ASSERT_AT_CLK(a_mac_bound, (state_q == ST_MAC) |-> (j_q <= two_r), "tap index past the kernel")
	`ASSERT_NEVER(a_idle_flush, (state_q == ST_IDLE) && flushing_q, "frame flush left unfinished")
	`ASSERT_AT_CLK(a_flush_left, (state_q == ST_FLUSH) |-> (left_q != '0), "flush with no output left")
	`ASSERT_AT_CLK(a_frame_clear, clear_frame |=> (count_q == '0), "band count kept after frame end")

endmodule

`default_nettype wire

>>> bench/band_kernel_blur_checker.sv
// Checker for band_kernel_blur_core: follows register writes, predicts the blurred
// bands of every accepted band and compares them with the result transfers.
// Depends on bkb_pkg for the payload types, widths and register indexes.
module band_kernel_blur_checker
	import bkb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_ready,
	input  bkb_in_t              sample_data,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  bkb_out_t             result_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output int                   blurred_owed,
	output int                   mismatch_total
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_LEN = 2 * RADIUS_CAP + 1;
	localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	logic [RADIUS_BITS-1:0]        radius_reg;
	logic [COEF_BITS-1:0]          weight [NUM_COEFS];
	logic signed [SAMPLE_BITS-1:0] window [WINDOW_LEN];
	logic [COUNT_BITS-1:0]         bands_seen;
	bkb_out_t                      blurred_due [$];
	int                            tally;

	function automatic int kernel_reach();
		int r;
		r = int'(radius_reg);
		if (r < 1) r = 1;
		if (r > RADIUS_CAP) r = RADIUS_CAP;
		if (r > DEF_MAX_RADIUS) r = DEF_MAX_RADIUS;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] blur_tap_sum(input int r);
		longint acc;
		acc = longint'(weight[0]) * longint'(window[r]);
		for (int d = 1; d <= r; d++) begin
			acc += longint'(weight[d]) * (longint'(window[r-d]) + longint'(window[r+d]));
		end
		acc += longint'(1) <<< (COEF_BITS - 1);
		acc = acc >>> COEF_BITS;
		if (acc > SAT_HI) acc = SAT_HI;
		if (acc < SAT_LO) acc = SAT_LO;
		return SAMPLE_BITS'(acc);
	endfunction

	task automatic clear_window();
		for (int i = 0; i < WINDOW_LEN; i++) window[i] = '0;
		bands_seen = '0;
	endtask

	task automatic shift_window(input logic signed [SAMPLE_BITS-1:0] x);
		for (int i = WINDOW_LEN - 1; i > 0; i--) window[i] = window[i-1];
		window[0] = x;
	endtask

	task automatic owe_blurred(input int r, input logic last);
		bkb_out_t e;
		e.blurred_value = blur_tap_sum(r);
		e.last_of_frame = last;
		blurred_due.push_back(e);
	endtask

	task automatic absorb_band(input bkb_in_t b);
		int r;
		int pending;
		r = kernel_reach();
		shift_window(b.band_value);
		if (bands_seen != COUNT_MAX) bands_seen++;
		if (int'(bands_seen) > r) owe_blurred(r, 1'b0);
		if (b.frame_end) begin
			pending = (int'(bands_seen) < r) ? int'(bands_seen) : r;
			for (int k = 0; k < r - pending; k++) shift_window('0);
			for (int k = 0; k < pending; k++) begin
				shift_window('0);
				owe_blurred(r, k == pending - 1);
			end
			clear_window();
		end
	endtask

	task automatic apply_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		int idx;
		idx = int'(addr[ADDR_BITS-1:2]);
		if (idx == REG_RADIUS) begin
			radius_reg = data[RADIUS_BITS-1:0];
		end else if (idx >= REG_COEF0 && idx - REG_COEF0 < NUM_COEFS) begin
			weight[idx - REG_COEF0] = data[COEF_BITS-1:0];
		end
	endtask

	task automatic check_result(input bkb_out_t got);
		bkb_out_t want;
		if (blurred_due.size() == 0) begin
			$error("result transfer with nothing owed: blurred_value %0d, last_of_frame %0b",
				got.blurred_value, got.last_of_frame);
			tally++;
		end else begin
			want = blurred_due.pop_front();
			if (got.blurred_value !== want.blurred_value) begin
				$error("blurred_value: expected %0d, got %0d", want.blurred_value,
					got.blurred_value);
				tally++;
			end
			if (got.last_of_frame !== want.last_of_frame) begin
				$error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
					got.last_of_frame);
				tally++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_reg = RADIUS_RESET;
			for (int i = 0; i < NUM_COEFS; i++) weight[i] = '0;
			weight[0] = COEF0_RESET;
			weight[1] = COEF1_RESET;
			clear_window();
			blurred_due.delete();
			tally = 0;
			blurred_owed <= 0;
			mismatch_total <= 0;
		end else begin
			if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
			if (sample_valid && sample_ready) absorb_band(sample_data);
			if (result_valid && result_ready) check_result(result_data);
			blurred_owed <= blurred_due.size();
			mismatch_total <= tally;
		end
	end

endmodule

>>> bench/band_kernel_blur_core_test.sv
// Top of the band_kernel_blur_core testbench: clock, reset, register writes, band
// stimulus and result back-pressure; the verdict comes from band_kernel_blur_checker.
// Depends on bkb_pkg, the block under test and the checker.
module band_kernel_blur_core_test
	import bkb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RANDOM_BANDS = 230;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  LONG_HOLD    = 300;
	localparam int  LONG_HOLD_AT = 60;
	localparam logic signed [SAMPLE_BITS-1:0] BAND_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] BAND_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	bkb_in_t              sample_data;
	logic                 result_valid;
	logic                 result_ready;
	bkb_out_t             result_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	int                   results_owed;
	int                   mismatches;
	int                   bands_sent;
	bit                   tx_steady;
	int                   cycles = 0;

	band_kernel_blur_core uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample_data(sample_data),
		.result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	band_kernel_blur_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample_data(sample_data),
		.result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.blurred_owed(results_owed), .mismatch_total(mismatches)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_band();
		case ($urandom_range(0, 5))
			0: return BAND_MAX;
			1: return BAND_MIN;
			2: return SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic write_reg(input int idx, input logic [DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_band(input logic signed [SAMPLE_BITS-1:0] v, input logic last);
		bkb_in_t item;
		int gap;
		item.band_value = v;
		item.frame_end = last;
		gap = tx_steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= item;
		do @(posedge clk); while (!sample_ready);
		bands_sent++;
	endtask

	// Drains the block so that registers may be written; also used at the end.
	task automatic settle();
		sample_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int gap;
		int taken;
		bit steady;
		result_ready <= 1'b0;
		taken = 0;
		steady = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 20 == 0) steady = ($urandom_range(0, 3) == 0);
			gap = steady ? 0 : $urandom_range(0, 17);
			if (taken == LONG_HOLD_AT) gap = LONG_HOLD;
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			taken++;
		end
	end

	initial begin
		int len;
		int split;
		int directed_bands;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		bands_sent = 0;
		tx_steady = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default weights and radius straight out of reset.
		send_band(BAND_MAX, 1'b0);
		send_band(BAND_MIN, 1'b0);
		send_band('0, 1'b1);
		settle();

		// Radius zero behaves as one; full-scale weights drive both saturation limits.
		write_reg(REG_RADIUS, 0);
		write_reg(REG_COEF0, 65535);
		write_reg(REG_COEF0 + 1, 65535);
		send_band(BAND_MAX, 1'b0);
		send_band(BAND_MAX, 1'b0);
		send_band(BAND_MAX, 1'b1);
		send_band(BAND_MIN, 1'b0);
		send_band(BAND_MIN, 1'b1);
		settle();

		// Radius seven clamps to six; a short frame and a single-band frame flush whole.
		write_reg(REG_RADIUS, 7);
		write_reg(REG_COEF0, 0);
		for (int d = 2; d < NUM_COEFS; d++) write_reg(REG_COEF0 + d, d * 4096);
		send_band(pick_band(), 1'b0);
		send_band(pick_band(), 1'b0);
		send_band(pick_band(), 1'b1);
		send_band(BAND_MAX, 1'b1);
		settle();

		// Outer weights must be ignored at radius three; the radius then drops mid-frame.
		write_reg(REG_RADIUS, 3);
		write_reg(REG_COEF0, 32768);
		write_reg(REG_COEF0 + 1, 8192);
		write_reg(REG_COEF0 + 2, 4096);
		write_reg(REG_COEF0 + 3, 2048);
		for (int d = 4; d < NUM_COEFS; d++) write_reg(REG_COEF0 + d, 65535);
		for (int i = 0; i < 5; i++) send_band(pick_band(), 1'b0);
		settle();
		write_reg(REG_RADIUS, 1);
		for (int i = 0; i < 3; i++) send_band(pick_band(), i == 2);
		settle();

		directed_bands = bands_sent;
		while (bands_sent < directed_bands + RANDOM_BANDS) begin
			tx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) begin
				settle();
				write_reg(REG_RADIUS, {29'($urandom), 3'($urandom_range(0, 7))});
				for (int d = 0; d < NUM_COEFS; d++) begin
					if ($urandom_range(0, 1) == 0) begin
						case ($urandom_range(0, 3))
							0: write_reg(REG_COEF0 + d, {16'($urandom), 16'd0});
							1: write_reg(REG_COEF0 + d, {16'($urandom), 16'hFFFF});
							2: write_reg(REG_COEF0 + d, {16'($urandom), 16'($urandom_range(0, 4095))});
							default: write_reg(REG_COEF0 + d, $urandom);
						endcase
					end
				end
			end
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 12);
			split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
			for (int i = 0; i < len; i++) begin
				if (split != 0 && i == split) begin
					settle();
					write_reg(REG_RADIUS, $urandom_range(0, 7));
				end
				send_band(pick_band(), i == len - 1);
			end
		end
		settle();

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
